@@ rtl/core/i2cee_pkg.sv @@
package i2cee_pkg;

    // command codes carried in the func field
    localparam logic [1:0] FN_TICK  = 2'd0;
    localparam logic [1:0] FN_WRITE = 2'd1;
    localparam logic [1:0] FN_READ  = 2'd2;

    // configuration register indexes (paddr[2])
    localparam logic REG_WAIT   = 1'b0;
    localparam logic REG_DEVICE = 1'b1;

    localparam logic [15:0] WAIT_TICKS_RST  = 16'd300;
    localparam logic [3:0]  DEVICE_CODE_RST = 4'd10;
    localparam logic [3:0]  BYTE_BITS       = 4'd8;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_ST0  = 4'd1,
        PH_ST1  = 4'd2,
        PH_ST2  = 4'd3,
        PH_TX0  = 4'd4,
        PH_TX1  = 4'd5,
        PH_TX2  = 4'd6,
        PH_ACK  = 4'd7,
        PH_RX0  = 4'd8,
        PH_RX1  = 4'd9,
        PH_MN0  = 4'd10,
        PH_MN1  = 4'd11,
        PH_SP0  = 4'd12,
        PH_SP1  = 4'd13,
        PH_SP2  = 4'd14
    } step_t;

    // what a phase puts on SDA
    typedef enum logic [1:0] {
        SDA_LO  = 2'd0,
        SDA_HI  = 2'd1,
        SDA_BIT = 2'd2,
        SDA_REL = 2'd3
    } sda_code_t;

    typedef struct packed {
        logic [1:0] func;
        logic [9:0] address;
        logic [7:0] write_data;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       control_nack;
        logic       address_nack;
        logic       third_nack;
    } out_item_t;

    typedef struct packed {
        logic drive;
        logic sda;
        logic scl;
    } pins_t;

    typedef struct packed {
        logic       busy;
        logic       wait_zero;
        logic [3:0] bit_count;
    } seq_status_t;

    function automatic logic phase_scl(step_t s);
        logic r;
        case (s)
            PH_ST2, PH_TX0, PH_TX2, PH_RX1, PH_MN1, PH_SP2: r = 1'b0;
            default: r = 1'b1;
        endcase
        return r;
    endfunction

    function automatic sda_code_t phase_sda(step_t s);
        sda_code_t r;
        case (s)
            PH_ST1, PH_ST2, PH_SP0:         r = SDA_LO;
            PH_TX0, PH_TX1, PH_TX2:         r = SDA_BIT;
            PH_ACK, PH_RX0, PH_RX1:         r = SDA_REL;
            default:                        r = SDA_HI;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] ctrl_byte(logic [3:0] dev, logic [1:0] blk, logic rw);
        return {dev, 1'b0, blk, rw};
    endfunction

endpackage

@@ rtl/core/i2cee_cfg.sv @@
module i2cee_cfg
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic [15:0] wait_ticks,
    output logic [3:0]  device_code
);
    import i2cee_pkg::*;

    logic        wr_en;
    logic [15:0] wait_ticks_reg;
    logic [3:0]  device_code_reg;

    // pready is tied high, so the access cycle always completes
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_ticks_reg  <= WAIT_TICKS_RST;
            device_code_reg <= DEVICE_CODE_RST;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_WAIT)
            begin
                wait_ticks_reg <= pwdata[15:0];
            end
            else
            begin
                device_code_reg <= pwdata[3:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_WAIT)
        begin
            prdata = {16'd0, wait_ticks_reg};
        end
        else
        begin
            prdata = {28'd0, device_code_reg};
        end
    end

    assign wait_ticks  = wait_ticks_reg;
    assign device_code = device_code_reg;

endmodule

@@ rtl/core/i2cee_seq.sv @@
module i2cee_seq
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  i2cee_pkg::in_item_t      item,
    input  logic [15:0]              wait_ticks,
    input  logic [3:0]               device_code,
    output i2cee_pkg::out_item_t     res,
    output i2cee_pkg::seq_status_t   status
);
    import i2cee_pkg::*;

    step_t       step_reg, step_next;
    logic [15:0] wait_count_reg, wait_count_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shifter_reg, shifter_next;
    logic        is_read_reg, is_read_next;
    logic [9:0]  saved_address_reg, saved_address_next;
    logic [7:0]  saved_data_reg, saved_data_next;
    logic [2:0]  nack_reg, nack_next;
    pins_t       pins_reg, pins_next;
    logic [1:0]  stage_reg, stage_next;
    logic [7:0]  last_read_reg, last_read_next;

    logic [15:0] wait_eff;
    logic [3:0]  bc_inc;
    logic        done;
    sda_code_t   code;

    assign wait_eff = (wait_ticks == 16'd0) ? 16'd1 : wait_ticks;
    assign bc_inc   = bit_count_reg + 4'd1;

    // phase sequencing: one tick per call
    always_comb
    begin
        step_next          = step_reg;
        wait_count_next    = wait_count_reg;
        bit_count_next     = bit_count_reg;
        shifter_next       = shifter_reg;
        is_read_next       = is_read_reg;
        saved_address_next = saved_address_reg;
        saved_data_next    = saved_data_reg;
        nack_next          = nack_reg;
        stage_next         = stage_reg;
        last_read_next     = last_read_reg;
        done               = 1'b0;

        if (step_reg == PH_IDLE)
        begin
            if (item.func == FN_WRITE || item.func == FN_READ)
            begin
                saved_address_next = item.address;
                saved_data_next    = item.write_data;
                is_read_next       = (item.func == FN_READ);
                nack_next          = 3'd0;
                stage_next         = 2'd0;
                step_next          = PH_ST0;
                wait_count_next    = 16'd1;
            end
        end
        else if (wait_count_reg >= wait_eff)
        begin
            case (step_reg)
                PH_ST0: step_next = PH_ST1;
                PH_ST1: step_next = PH_ST2;
                PH_ST2:
                begin
                    shifter_next   = ctrl_byte(device_code, saved_address_reg[9:8],
                                               stage_reg != 2'd0);
                    bit_count_next = 4'd0;
                    step_next      = PH_TX0;
                end
                PH_TX0: step_next = PH_TX1;
                PH_TX1: step_next = PH_TX2;
                PH_TX2:
                begin
                    shifter_next   = {shifter_reg[6:0], 1'b0};
                    bit_count_next = bc_inc;
                    step_next      = (bc_inc < BYTE_BITS) ? PH_TX0 : PH_ACK;
                end
                PH_ACK:
                begin
                    if (item.sda_in)
                    begin
                        nack_next[stage_reg] = 1'b1;
                    end
                    if (stage_reg == 2'd0)
                    begin
                        stage_next     = 2'd1;
                        shifter_next   = saved_address_reg[7:0];
                        bit_count_next = 4'd0;
                        step_next      = PH_TX0;
                    end
                    else if (stage_reg == 2'd1)
                    begin
                        stage_next = 2'd2;
                        if (is_read_reg)
                        begin
                            step_next = PH_ST0;   // repeated start
                        end
                        else
                        begin
                            shifter_next   = saved_data_reg;
                            bit_count_next = 4'd0;
                            step_next      = PH_TX0;
                        end
                    end
                    else if (is_read_reg)
                    begin
                        shifter_next   = 8'd0;
                        bit_count_next = 4'd0;
                        step_next      = PH_RX0;
                    end
                    else
                    begin
                        step_next = PH_SP0;
                    end
                end
                PH_RX0:
                begin
                    shifter_next = {shifter_reg[6:0], item.sda_in};
                    step_next    = PH_RX1;
                end
                PH_RX1:
                begin
                    bit_count_next = bc_inc;
                    if (bc_inc < BYTE_BITS)
                    begin
                        step_next = PH_RX0;
                    end
                    else
                    begin
                        last_read_next = shifter_reg;
                        step_next      = PH_MN0;
                    end
                end
                PH_MN0: step_next = PH_MN1;
                PH_MN1: step_next = PH_SP0;
                PH_SP0: step_next = PH_SP1;
                PH_SP1: step_next = PH_SP2;
                PH_SP2:
                begin
                    step_next = PH_IDLE;
                    done      = 1'b1;
                end
                default: step_next = PH_IDLE;
            endcase
            wait_count_next = (step_next == PH_IDLE) ? 16'd0 : 16'd1;
        end
        else
        begin
            wait_count_next = wait_count_reg + 16'd1;
        end
    end

    // pin levels of the phase now entered; idle holds the last levels
    always_comb
    begin
        code = phase_sda(step_next);
        if (step_next == PH_IDLE)
        begin
            pins_next = pins_reg;
        end
        else
        begin
            pins_next.scl   = phase_scl(step_next);
            pins_next.drive = (code != SDA_REL);
            case (code)
                SDA_LO:  pins_next.sda = 1'b0;
                SDA_BIT: pins_next.sda = shifter_next[7];
                default: pins_next.sda = 1'b1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg          <= PH_IDLE;
            wait_count_reg    <= 16'd0;
            bit_count_reg     <= 4'd0;
            shifter_reg       <= 8'd0;
            is_read_reg       <= 1'b0;
            saved_address_reg <= 10'd0;
            saved_data_reg    <= 8'd0;
            nack_reg          <= 3'd0;
            pins_reg          <= '{drive: 1'b1, sda: 1'b1, scl: 1'b1};
            stage_reg         <= 2'd0;
            last_read_reg     <= 8'd0;
        end
        else if (en)
        begin
            step_reg          <= step_next;
            wait_count_reg    <= wait_count_next;
            bit_count_reg     <= bit_count_next;
            shifter_reg       <= shifter_next;
            is_read_reg       <= is_read_next;
            saved_address_reg <= saved_address_next;
            saved_data_reg    <= saved_data_next;
            nack_reg          <= nack_next;
            pins_reg          <= pins_next;
            stage_reg         <= stage_next;
            last_read_reg     <= last_read_next;
        end
    end

    always_comb
    begin
        res.scl_level    = pins_next.scl;
        res.sda_level    = pins_next.sda;
        res.sda_drive    = pins_next.drive;
        res.busy_res     = (step_next != PH_IDLE);
        res.done_res     = done;
        res.read_byte    = last_read_next;
        res.control_nack = nack_next[0];
        res.address_nack = nack_next[1];
        res.third_nack   = nack_next[2];
    end

    assign status.busy      = (step_reg != PH_IDLE);
    assign status.wait_zero = (wait_count_reg == 16'd0);
    assign status.bit_count = bit_count_reg;

endmodule

@@ rtl/core/i2c_eeprom_byte_master.sv @@
// I2C byte master for a small serial EEPROM: byte write and random read.
// Input stream (s_*): one transfer per bus tick. It carries the sampled SDA
// level and, in s_tuser, a command: tick only, byte write or random read.
// A command is taken only while no transaction runs; otherwise it is ignored.
// Output stream (m_*): exactly one transfer per input transfer, with SCL/SDA
// pin levels, SDA drive enable, busy, a done pulse, the last read byte and
// the three NACK flags of the current or last transaction.
// Each bus phase holds its levels for wait_ticks ticks (0 acts as 1).
// Configuration over APB: wait_ticks at 0x0, device_code at 0x4; write
// only while the block is idle.
// A tick accepted on s_* passes the input register, then the result register,
// before it appears on m_tdata. Throughput: one tick per cycle while the
// result stream is not stalled, set by the phase sequencer.
// When m_tready is low the result register holds; the input register still
// takes one more tick if it was empty, then s_tready drops until the output drains.
// Reset: sequencer idle, pins at SCL high, SDA high and driven, registers
// at wait_ticks 300 and device_code 0xA.
module i2c_eeprom_byte_master
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address[9:0], write_data[17:10], sda_in[18], zero pad
    input  logic [1:0]  s_tuser,   // func[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // scl_level[0], sda_level[1], sda_drive[2], busy_res[3],
                                   // done_res[4], read_byte[12:5], control_nack[13],
                                   // address_nack[14], third_nack[15]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import i2cee_pkg::*;

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;

    logic        adv;          // sequencer consumes the held tick
    logic        in_take;
    in_item_t    in_item;
    out_item_t   res;
    seq_status_t status;
    logic [15:0] wait_ticks;
    logic [3:0]  device_code;

    assign pready = 1'b1;

    // unpack the incoming transfer
    assign in_item.func       = s_tuser;
    assign in_item.address    = s_tdata[9:0];
    assign in_item.write_data = s_tdata[17:10];
    assign in_item.sda_in     = s_tdata[18];

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign in_take  = s_tvalid && s_tready;

    i2cee_cfg u_cfg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .wait_ticks  (wait_ticks),
        .device_code (device_code)
    );

    i2cee_seq u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv),
        .item        (in_item_reg),
        .wait_ticks  (wait_ticks),
        .device_code (device_code),
        .res         (res),
        .status      (status)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_item;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_item_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_item_reg.third_nack, out_item_reg.address_nack,
                       out_item_reg.control_nack, out_item_reg.read_byte,
                       out_item_reg.done_res, out_item_reg.busy_res,
                       out_item_reg.sda_drive, out_item_reg.sda_level,
                       out_item_reg.scl_level};

    // input side stalls only behind a held tick and a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

    // a running transaction always has a started wait period
    a_wait_running: assert property (@(posedge clk) disable iff (!rst_n)
        status.busy |-> !status.wait_zero)
        else $error("wait counter zero while busy");

    // the bit counter never passes one byte
    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        status.bit_count <= BYTE_BITS)
        else $error("bit counter out of range");

endmodule
